// ===== rtl/fixed_block_pool_allocator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator: assertion macros
// Clocked concurrent assertion wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define FBPA_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock and reset.
`define FBPA_ASSERT(label, prop, msg) \
  `FBPA_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator: package
// Sizes, opcodes, status codes, controller states and link memory port type.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int LINK_W     = IDX_W + 1;
  localparam int CNT_W      = IDX_W + 1;

  localparam logic [LINK_W-1:0] NONE_MARK = LINK_W'(NUM_BLOCKS);
  localparam logic [CNT_W-1:0]  POOL_MAX  = CNT_W'(NUM_BLOCKS);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_RESET = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LINK,
    ST_PUSH,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic              next_we;
    logic [IDX_W-1:0]  next_addr;
    logic [LINK_W-1:0] next_data;
    logic              prev_we;
    logic [IDX_W-1:0]  prev_addr;
    logic [LINK_W-1:0] prev_data;
  } link_wr_t;

endpackage

// ===== rtl/fbpa_links.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator: link memories
// Next and prev link arrays, one write port each, shared registered read.
// ----------------------------------------------------------------------------
module fbpa_links (
  input  logic                           clk_i,
  input  fbpa_pkg::link_wr_t             wr_i,
  input  logic                           rd_en_i,
  input  logic [fbpa_pkg::IDX_W-1:0]     rd_addr_i,
  output logic [fbpa_pkg::LINK_W-1:0]    next_rdata_o,
  output logic [fbpa_pkg::LINK_W-1:0]    prev_rdata_o
);
  import fbpa_pkg::*;

  logic [LINK_W-1:0] next_mem [NUM_BLOCKS];
  logic [LINK_W-1:0] prev_mem [NUM_BLOCKS];
  logic [LINK_W-1:0] next_rdata_q;
  logic [LINK_W-1:0] prev_rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.next_we) begin
      next_mem[wr_i.next_addr] <= wr_i.next_data;
    end
    if (wr_i.prev_we) begin
      prev_mem[wr_i.prev_addr] <= wr_i.prev_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      next_rdata_q <= next_mem[rd_addr_i];
      prev_rdata_q <= prev_mem[rd_addr_i];
    end
  end

  assign next_rdata_o = next_rdata_q;
  assign prev_rdata_o = prev_rdata_q;

endmodule

// ===== rtl/fixed_block_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Equal-size blocks kept on doubly linked free and allocated lists.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o) carries opcode_i and
//   block_index_i: allocate, free or reset the pool. Each request yields one
//   response on the result channel (out_valid_o / out_stall_i) with done_ok_o,
//   status_o, granted_index_o and both list counts.
//   The response is registered and shows in the cycle after the request is taken.
//   Allocate and free issue one link read, then pass through the LINK, PUSH
//   and CLEAR write states, set by the single write port of each link memory.
//   Reset requests and writes of cfg_wdata_i (pool size) rebuild the chain
//   with a sweep over pool_blocks entries, one entry per cycle; no request is
//   taken meanwhile. A failed request (empty pool, index out of range,
//   unused opcode) leaves the controller idle.
//   After rst_ni the pool size is 256 and a sweep runs before the
//   first request is taken.
//   While out_stall_i holds a response, no new request is taken; work already
//   in flight on the link memories still completes.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fbpa_pkg::CNT_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic [fbpa_pkg::IDX_W-1:0]    block_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          done_ok_o,
  output logic [1:0]                    status_o,
  output logic [fbpa_pkg::IDX_W-1:0]    granted_index_o,
  output logic [fbpa_pkg::CNT_W-1:0]    free_count_o,
  output logic [fbpa_pkg::CNT_W-1:0]    used_count_o
);
  import fbpa_pkg::*;

  function automatic logic [LINK_W-1:0] norm_link(input logic [LINK_W-1:0] v);
    return v[LINK_W-1] ? NONE_MARK : v;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_pool(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > POOL_MAX) begin
      r = POOL_MAX;
    end
    return r;
  endfunction

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  pool_blocks_q, pool_blocks_d;
  logic [LINK_W-1:0] free_head_q, free_head_d;
  logic [LINK_W-1:0] used_head_q, used_head_d;
  logic [CNT_W-1:0]  free_total_q, free_total_d;
  logic [CNT_W-1:0]  used_total_q, used_total_d;
  logic [IDX_W-1:0]  sweep_q, sweep_d;
  logic [IDX_W-1:0]  blk_q, blk_d;
  logic [LINK_W-1:0] other_q, other_d;
  logic              op_free_q, op_free_d;

  logic              out_valid_q, out_valid_d;
  logic              done_ok_q, done_ok_d;
  logic [1:0]        status_q, status_d;
  logic [IDX_W-1:0]  granted_q, granted_d;
  logic [CNT_W-1:0]  free_cnt_q, free_cnt_d;
  logic [CNT_W-1:0]  used_cnt_q, used_cnt_d;

  logic              in_acc;
  logic              sweep_last;
  link_wr_t          wr;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [LINK_W-1:0] next_rdata;
  logic [LINK_W-1:0] prev_rdata;

  fbpa_links u_links (
    .clk_i        (clk_i),
    .wr_i         (wr),
    .rd_en_i      (rd_en),
    .rd_addr_i    (rd_addr),
    .next_rdata_o (next_rdata),
    .prev_rdata_o (prev_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE) | (out_valid_q & out_stall_i) | cfg_we_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign sweep_last = (CNT_W'(sweep_q) + CNT_W'(1)) == pool_blocks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SWEEP;
      pool_blocks_q <= POOL_MAX;
      free_head_q   <= '0;
      used_head_q   <= NONE_MARK;
      free_total_q  <= POOL_MAX;
      used_total_q  <= '0;
      sweep_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      pool_blocks_q <= pool_blocks_d;
      free_head_q   <= free_head_d;
      used_head_q   <= used_head_d;
      free_total_q  <= free_total_d;
      used_total_q  <= used_total_d;
      sweep_q       <= sweep_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q      <= blk_d;
    other_q    <= other_d;
    op_free_q  <= op_free_d;
    done_ok_q  <= done_ok_d;
    status_q   <= status_d;
    granted_q  <= granted_d;
    free_cnt_q <= free_cnt_d;
    used_cnt_q <= used_cnt_d;
  end

  always_comb begin
    state_d       = state_q;
    pool_blocks_d = pool_blocks_q;
    free_head_d   = free_head_q;
    used_head_d   = used_head_q;
    free_total_d  = free_total_q;
    used_total_d  = used_total_q;
    sweep_d       = sweep_q;
    blk_d         = blk_q;
    other_d       = other_q;
    op_free_d     = op_free_q;
    out_valid_d   = out_valid_q & out_stall_i;
    done_ok_d     = done_ok_q;
    status_d      = status_q;
    granted_d     = granted_q;
    free_cnt_d    = free_cnt_q;
    used_cnt_d    = used_cnt_q;
    wr            = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;

    case (state_q)
      ST_SWEEP: begin
        wr.next_we   = 1'b1;
        wr.next_addr = sweep_q;
        wr.next_data = sweep_last ? NONE_MARK : (LINK_W'(sweep_q) + LINK_W'(1));
        wr.prev_we   = 1'b1;
        wr.prev_addr = sweep_q;
        wr.prev_data = (sweep_q == '0) ? NONE_MARK : (LINK_W'(sweep_q) - LINK_W'(1));
        if (sweep_last) begin
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + IDX_W'(1);
        end
      end
      ST_LINK: begin
        wr.next_we   = ~prev_rdata[LINK_W-1];
        wr.next_addr = prev_rdata[IDX_W-1:0];
        wr.next_data = next_rdata;
        wr.prev_we   = ~next_rdata[LINK_W-1];
        wr.prev_addr = next_rdata[IDX_W-1:0];
        wr.prev_data = prev_rdata;
        if (!op_free_q) begin
          free_head_d = norm_link(next_rdata);
        end else if (used_head_q == LINK_W'(blk_q)) begin
          used_head_d = norm_link(next_rdata);
        end
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        wr.next_we   = 1'b1;
        wr.next_addr = blk_q;
        wr.next_data = norm_link(other_q);
        wr.prev_we   = ~other_q[LINK_W-1];
        wr.prev_addr = other_q[IDX_W-1:0];
        wr.prev_data = LINK_W'(blk_q);
        state_d      = ST_CLEAR;
      end
      ST_CLEAR: begin
        wr.prev_we   = 1'b1;
        wr.prev_addr = blk_q;
        wr.prev_data = NONE_MARK;
        state_d      = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          done_ok_d = 1'b0;
          status_d  = STATUS_OK;
          granted_d = '0;
          case (opcode_i)
            OP_ALLOC: begin
              if (!free_head_q[LINK_W-1]) begin
                rd_en     = 1'b1;
                rd_addr   = free_head_q[IDX_W-1:0];
                blk_d     = free_head_q[IDX_W-1:0];
                other_d   = used_head_q;
                op_free_d = 1'b0;
                used_head_d = free_head_q;
                if (free_total_q != '0) begin
                  free_total_d = free_total_q - CNT_W'(1);
                end
                if (used_total_q < pool_blocks_q) begin
                  used_total_d = used_total_q + CNT_W'(1);
                end
                done_ok_d = 1'b1;
                granted_d = free_head_q[IDX_W-1:0];
                state_d   = ST_LINK;
              end else begin
                status_d = STATUS_EMPTY;
              end
            end
            OP_FREE: begin
              if (CNT_W'(block_index_i) >= pool_blocks_q) begin
                status_d = STATUS_RANGE;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = block_index_i;
                blk_d       = block_index_i;
                other_d     = free_head_q;
                op_free_d   = 1'b1;
                free_head_d = LINK_W'(block_index_i);
                if (used_total_q != '0) begin
                  used_total_d = used_total_q - CNT_W'(1);
                end
                if (free_total_q < pool_blocks_q) begin
                  free_total_d = free_total_q + CNT_W'(1);
                end
                done_ok_d = 1'b1;
                state_d   = ST_LINK;
              end
            end
            OP_RESET: begin
              free_head_d  = '0;
              used_head_d  = NONE_MARK;
              free_total_d = pool_blocks_q;
              used_total_d = '0;
              sweep_d      = '0;
              done_ok_d    = 1'b1;
              state_d      = ST_SWEEP;
            end
            default: begin
            end
          endcase
          out_valid_d = 1'b1;
          free_cnt_d  = free_total_d;
          used_cnt_d  = used_total_d;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // pool size write rebuilds the free chain
    if (cfg_we_i) begin
      pool_blocks_d = clamp_pool(cfg_wdata_i);
      free_head_d   = '0;
      used_head_d   = NONE_MARK;
      free_total_d  = clamp_pool(cfg_wdata_i);
      used_total_d  = '0;
      sweep_d       = '0;
      state_d       = ST_SWEEP;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign done_ok_o       = done_ok_q;
  assign status_o        = status_q;
  assign granted_index_o = granted_q;
  assign free_count_o    = free_cnt_q;
  assign used_count_o    = used_cnt_q;

endmodule

// ===== rtl/fbpa_checker.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator: port checker
// Watches the top-level ports and flags inconsistent responses.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_unit_macros.svh"

module fbpa_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic                          done_ok_o,
  input  logic [1:0]                    status_o,
  input  logic [fbpa_pkg::IDX_W-1:0]    granted_index_o,
  input  logic [fbpa_pkg::CNT_W-1:0]    free_count_o,
  input  logic [fbpa_pkg::CNT_W-1:0]    used_count_o
);
  import fbpa_pkg::*;

  logic [CNT_W:0] count_sum;
  assign count_sum = {1'b0, free_count_o} + {1'b0, used_count_o};

  `FBPA_ASSERT(a_resp_held, out_valid_o && out_stall_i |=> out_valid_o, "response dropped")
  `FBPA_ASSERT(a_resp_next, in_valid_i && !in_stall_o |=> out_valid_o, "no response to request")
  `FBPA_ASSERT(a_ok_status, out_valid_o && done_ok_o |-> status_o == STATUS_OK, "ok with error")
  `FBPA_ASSERT(a_grant_zero, out_valid_o && !done_ok_o |-> granted_index_o == '0, "stray grant")
  `FBPA_ASSERT(a_count_sum, out_valid_o |-> count_sum <= (CNT_W+1)'(NUM_BLOCKS), "count overflow")

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_fbpa_checker (.*);
